// ===== rtl/scpp_pkg.sv =====
// scpp_pkg: constants shared by the constant-power stereo panner
// holds default widths, gain polynomial coefficients and mode codes
// no dependencies
package scpp_pkg;

   // default widths
   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int PAN_FRAC_BITS_DEF = 16;

   // gains are unsigned q1.16 in 0..1.0
   localparam int GAIN_W = 17;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   // quarter sine polynomial coefficients
   localparam logic [16:0] POLY_A = 17'd102944;
   localparam logic [15:0] POLY_B = 16'd42048;
   localparam logic [12:0] POLY_C = 13'd4640;

   // rounding offset for a q.16 value
   localparam logic [15:0] ROUND_HALF = 16'h8000;

   // pan mode codes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_GAIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MONO  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

endpackage

// ===== rtl/scpp_req_if.sv =====
// scpp_req_if: request channel of the panner, one stereo word with pan
// valid/ready handshake; depends on scpp_pkg
interface scpp_req_if
   import scpp_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int PAN_FRAC_BITS = PAN_FRAC_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic [PAN_FRAC_BITS:0]        pan_position;

   modport source (output valid, left_in, right_in, pan_position, input ready);
   modport sink   (input valid, left_in, right_in, pan_position, output ready);
endinterface

// ===== rtl/scpp_rsp_if.sv =====
// scpp_rsp_if: response channel of the panner, one stereo result word
// valid/ready handshake; depends on scpp_pkg
interface scpp_rsp_if
   import scpp_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/stereo_constant_power_panner.sv =====
// stereo_constant_power_panner: sine/cosine gain panner, eight stage pipeline
// depends on scpp_pkg, scpp_req_if and scpp_rsp_if
//
// Usage
//   req_ch carries one stereo word per handshake: left_in, right_in and a
//   pan position in q1.PAN_FRAC_BITS (values above 1.0 act as 1.0).
//   rsp_ch returns one stereo word per request, in order, rounded and
//   saturated to SAMPLE_BITS.
//   csr_write_enable/csr_write_data write the pan mode: 0 gain panning,
//   1 crossfeed blend, 2 mono-summed gain panning; code 3 is ignored. Write the
//   mode only while no word is in flight.
// Pipeline and throughput
//   an accepted request passes every stage to its response word at the output
//   register; one word per cycle sustained while rsp_ch is ready. The depth
//   is set by the pan clamp stage, the four multiply stages of the gain
//   polynomial, then sample multiply, accumulate and saturate stages.
// Reset and stall
//   reset empties the pipeline and sets gain panning mode. When rsp_ch
//   stalls, words pack up into empty stages; req_ch.ready drops only once
//   every stage holds a word.
module stereo_constant_power_panner
   import scpp_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int PAN_FRAC_BITS = PAN_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   scpp_req_if.sink          req_ch,
   scpp_rsp_if.source        rsp_ch,
   input  logic              csr_write_enable,
   input  logic [MODE_W-1:0] csr_write_data
);

   localparam int NST = 8;                  // pipeline stages
   localparam int SB  = SAMPLE_BITS;
   localparam int PW  = PAN_FRAC_BITS + 1;
   localparam int PRW = SB + 19;            // (sb+1) x 18 product
   localparam int ACW = SB + 20;            // sum of two products
   localparam int RW  = ACW - 16;           // rounded accumulator
   localparam logic [PW-1:0] PAN_MAX = {1'b1, {PAN_FRAC_BITS{1'b0}}};
   localparam logic signed [RW-1:0] SAT_HI = {{5{1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = {{5{1'b1}}, {(SB-1){1'b0}}};

   // mode register
   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write_enable && (csr_write_data != MODE_RSVD)) begin
         mode_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GAIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // stage valids and advance chain; a stage moves when empty or drained
   logic [NST:1] vld_ff;
   logic [NST:1] vld_in;
   logic [NST:1] adv;
   logic [NST:1] vld_prev;

   always_comb begin
      adv[NST] = !vld_ff[NST] || rsp_ch.ready;
      for (int k = NST - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_prev = {vld_ff[NST-1:1], req_ch.valid};
      for (int k = 1; k <= NST; k++) begin
         vld_in[k] = adv[k] ? vld_prev[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = adv[1];

   // sample line through the gain stages
   logic signed [SB-1:0] lsm_ff [1:5];
   logic signed [SB-1:0] rsm_ff [1:5];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         lsm_ff[1] <= req_ch.left_in;
         rsm_ff[1] <= req_ch.right_in;
      end
      for (int k = 2; k <= 5; k++) begin
         if (adv[k]) begin
            lsm_ff[k] <= lsm_ff[k-1];
            rsm_ff[k] <= rsm_ff[k-1];
         end
      end
   end

   // stage 1: clamp pan, scale to q1.16, form both angles
   logic [PW-1:0]           pan_cl;
   logic [PW+15:0]          pan_wide;
   logic [GAIN_W-1:0]       pos_in [2];
   logic [GAIN_W-1:0]       pos_ff [1:4][2];

   always_comb begin
      pan_cl    = (req_ch.pan_position > PAN_MAX) ? PAN_MAX : req_ch.pan_position;
      pan_wide  = {pan_cl, 16'b0};
      pos_in[0] = GAIN_W'(pan_wide >> PAN_FRAC_BITS);
      pos_in[1] = GAIN_ONE - pos_in[0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pos_ff[1] <= pos_in;
      end
      for (int k = 2; k <= 4; k++) begin
         if (adv[k]) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // stage 2: x squared
   logic [33:0]       sq_prod [2];
   logic [GAIN_W-1:0] sq_in   [2];
   logic [GAIN_W-1:0] sq_ff   [2:3][2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sq_prod[i] = {17'b0, pos_ff[1][i]} * {17'b0, pos_ff[1][i]} + 34'(ROUND_HALF);
         sq_in[i]   = sq_prod[i][32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sq_ff[2] <= sq_in;
      end
      if (adv[3]) begin
         sq_ff[3] <= sq_ff[2];
      end
   end

   // stage 3: u = b - c*x2
   logic [29:0] u_prod [2];
   logic [15:0] u_in   [2];
   logic [15:0] u_ff   [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         u_prod[i] = {13'b0, sq_ff[2][i]} * {17'b0, POLY_C} + 30'(ROUND_HALF);
         u_in[i]   = POLY_B - {2'b0, u_prod[i][29:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         u_ff <= u_in;
      end
   end

   // stage 4: v = a - x2*u
   logic [32:0]       v_prod [2];
   logic [GAIN_W-1:0] v_in   [2];
   logic [GAIN_W-1:0] v_ff   [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         v_prod[i] = {16'b0, sq_ff[3][i]} * {17'b0, u_ff[i]} + 33'(ROUND_HALF);
         v_in[i]   = POLY_A - v_prod[i][32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         v_ff <= v_in;
      end
   end

   // stage 5: gain = min(1.0, x*v), plus mono sum
   logic [33:0]          g_prod [2];
   logic [GAIN_W:0]      g_raw  [2];
   logic [GAIN_W-1:0]    gain_in [2];
   logic [GAIN_W-1:0]    gain_ff [2];
   logic signed [SB:0]   sum_in;
   logic signed [SB:0]   sum_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         g_prod[i]  = {17'b0, pos_ff[4][i]} * {17'b0, v_ff[i]} + 34'(ROUND_HALF);
         g_raw[i]   = g_prod[i][33:16];
         gain_in[i] = (g_raw[i] > {1'b0, GAIN_ONE}) ? GAIN_ONE : g_raw[i][GAIN_W-1:0];
      end
      sum_in = {lsm_ff[4][SB-1], lsm_ff[4]} + {rsm_ff[4][SB-1], rsm_ff[4]};
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         gain_ff <= gain_in;
         sum_ff  <= sum_in;
      end
   end

   // stage 6: direct and crossfeed products per channel
   logic signed [SB:0]      dir_a   [2];
   logic signed [SB:0]      crs_a   [2];
   logic [GAIN_W-1:0]       crs_g   [2];
   logic signed [PRW-1:0]   dir_in  [2];
   logic signed [PRW-1:0]   crs_in  [2];
   logic signed [PRW-1:0]   dir_ff  [2];
   logic signed [PRW-1:0]   crs_ff  [2];

   always_comb begin
      dir_a[0] = (mode_ff == MODE_MONO) ? sum_ff : {lsm_ff[5][SB-1], lsm_ff[5]};
      dir_a[1] = (mode_ff == MODE_MONO) ? sum_ff : {rsm_ff[5][SB-1], rsm_ff[5]};
      crs_a[0] = {rsm_ff[5][SB-1], rsm_ff[5]};
      crs_a[1] = {lsm_ff[5][SB-1], lsm_ff[5]};
      crs_g[0] = (mode_ff == MODE_BLEND) ? GAIN_ONE - gain_ff[1] : '0;
      crs_g[1] = (mode_ff == MODE_BLEND) ? GAIN_ONE - gain_ff[0] : '0;
      for (int i = 0; i < 2; i++) begin
         dir_in[i] = dir_a[i] * $signed({1'b0, gain_ff[i]});
         crs_in[i] = crs_a[i] * $signed({1'b0, crs_g[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         dir_ff <= dir_in;
         crs_ff <= crs_in;
      end
   end

   // stage 7: accumulate and round half up to whole samples
   logic signed [ACW-1:0] acc   [2];
   logic signed [RW-1:0]  rnd_in [2];
   logic signed [RW-1:0]  rnd_ff [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         acc[i] = {dir_ff[i][PRW-1], dir_ff[i]} + {crs_ff[i][PRW-1], crs_ff[i]}
                  + $signed({{(ACW-16){1'b0}}, ROUND_HALF});
         rnd_in[i] = acc[i][ACW-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         rnd_ff <= rnd_in;
      end
   end

   // stage 8: saturate into the output register
   logic signed [SB-1:0] sat_in [2];
   logic signed [SB-1:0] sat_ff [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (rnd_ff[i] > SAT_HI) begin
            sat_in[i] = SAT_HI[SB-1:0];
         end else if (rnd_ff[i] < SAT_LO) begin
            sat_in[i] = SAT_LO[SB-1:0];
         end else begin
            sat_in[i] = rnd_ff[i][SB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         sat_ff <= sat_in;
      end
   end

   assign rsp_ch.valid     = vld_ff[NST];
   assign rsp_ch.left_out  = sat_ff[0];
   assign rsp_ch.right_out = sat_ff[1];

`ifndef SYNTH
   // reserved mode code leaves the mode alone
   a_mode_rsvd: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && (csr_write_data == MODE_RSVD) |=> $stable(mode_ff))
      else $error("reserved mode write changed the mode");

   // a legal mode write takes effect on the next cycle
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && (csr_write_data != MODE_RSVD)
      |=> mode_ff == $past(csr_write_data))
      else $error("mode write lost");

   // a blocked middle stage keeps its word
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && !adv[4] |=> vld_ff[4] && $stable(v_ff[0]) && $stable(v_ff[1]))
      else $error("stalled stage lost its word");

   // a word leaving the round stage lands in the output register
   a_last_move: assert property (@(posedge clock) disable iff (reset)
      adv[NST] && vld_ff[NST-1] |=> vld_ff[NST])
      else $error("word dropped before the output register");

   // gains never exceed unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (gain_ff[0] <= GAIN_ONE) && (gain_ff[1] <= GAIN_ONE))
      else $error("gain above unity");
`endif

endmodule
